// File: sv/aging_address_blocklist_top_macros.svh
// ----------------------------------------------------------------------------
// aging_address_blocklist_top_macros.svh
// Assertion shorthands used by the blocklist checker.
// ----------------------------------------------------------------------------
`ifndef AGING_ADDRESS_BLOCKLIST_TOP_MACROS_SVH
`define AGING_ADDRESS_BLOCKLIST_TOP_MACROS_SVH

// Implication held on every clock edge outside reset
`define AAB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define AAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/aab_pkg.sv
// ----------------------------------------------------------------------------
// aab_pkg
// Types and constants of the aging address blocklist.
// ----------------------------------------------------------------------------
package aab_pkg;

	localparam int ADDR_W     = 48;
	localparam int STAMP_W    = 32;
	localparam int HITS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SLOT_W     = 4;

	localparam logic [HITS_W-1:0] HITS_MAX = '1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd1;

	// Input command codes
	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// One table entry as stored in memory
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [STAMP_W-1:0] stamp;
		logic [HITS_W-1:0]  hits;
	} entry_t;

endpackage

// File: sv/aging_address_blocklist_top.sv
// A result is loaded once the walk of the table for its input beat is done.
// No new item is taken before then; each item's walk of the table goes
// through the single memory read port, one entry per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset clears the per-entry valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// aging_address_blocklist_top
// Station address table with timestamps and hit counts. Add beats record a
// hit (on a miss taking the first empty slot, else replacing the oldest entry), find beats report listed state.
// ----------------------------------------------------------------------------
module aging_address_blocklist_top
	import aab_pkg::*;
#(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  cmd,
	input  logic [ADDR_W-1:0]     station_address,
	input  logic [STAMP_W-1:0]    now_ms,
	// output channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  listed,
	output logic                  matched,
	output logic [SLOT_W-1:0]     slot_index
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// configuration registers
	logic [HITS_W-1:0] timeout_q;
	logic [HITS_W-1:0] limit_q;

	// sequencer
	state_t state_q, state_d;
	logic   rd_en;
	logic   done_fire;
	logic   scan_last;

	// latched input beat
	logic               cmd_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [STAMP_W-1:0] now_q;

	// table memory and valid bits
	entry_t             mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] entry_vld_q;
	logic [IDX_W-1:0]   rd_idx_q;
	entry_t             rd_entry_s1;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic               rd_en_s1;

	// scan results
	logic               hit_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [STAMP_W-1:0] hit_stamp_q;
	logic [HITS_W-1:0]  hit_hits_q;
	logic [STAMP_W-1:0] hit_elapsed_q;
	logic               empty_found_q;
	logic [IDX_W-1:0]   empty_idx_q;
	logic               old_found_q;
	logic [IDX_W-1:0]   old_idx_q;
	logic [STAMP_W-1:0] old_elapsed_q;

	// entry under inspection
	entry_t             cur_entry;
	logic [STAMP_W-1:0] cur_elapsed;

	// write back and result
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_entry;
	logic [IDX_W-1:0]   tgt_idx;
	logic               expired;
	logic               res_listed;
	logic               res_matched;
	logic [IDX_W-1:0]   res_idx;

	// output register
	logic               out_valid_q;
	logic               listed_q;
	logic               matched_q;
	logic [SLOT_W-1:0]  slot_q;

	assign scan_last = (rd_idx_q == IDX_W'(TABLE_ENTRIES - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_SCAN;
			ST_SCAN:  if (scan_last) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DONE;
			ST_DONE:  if (done_fire) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SCAN:  rd_en = 1'b1;
			ST_DRAIN: ;
			ST_DONE:  done_fire = !out_valid_q || out_ready;
			default:  ;
		endcase
	end

	// entry as read: a never-written slot reads as all zero
	always_comb begin
		cur_entry   = rd_vld_s1 ? rd_entry_s1 : '0;
		cur_elapsed = now_q - cur_entry.stamp;
	end

	// final decision, write back and result
	always_comb begin
		tgt_idx     = empty_found_q ? empty_idx_q : (old_found_q ? old_idx_q : '0);
		expired     = hit_elapsed_q > {{(STAMP_W-HITS_W){1'b0}}, timeout_q};
		wr_en       = 1'b0;
		wr_idx      = tgt_idx;
		wr_entry    = '0;
		res_listed  = 1'b0;
		res_matched = hit_found_q;
		res_idx     = hit_found_q ? hit_idx_q : '0;
		if (cmd_q == CMD_FIND) begin
			res_listed = hit_found_q && !expired && (hit_hits_q >= limit_q);
		end else if (hit_found_q) begin
			wr_en          = done_fire;
			wr_idx         = hit_idx_q;
			wr_entry.addr  = addr_q;
			if (expired) begin
				wr_entry.stamp = now_q;
				wr_entry.hits  = HITS_W'(1);
			end else begin
				wr_entry.stamp = hit_stamp_q;
				wr_entry.hits  = (hit_hits_q == HITS_MAX) ? HITS_MAX : hit_hits_q + HITS_W'(1);
			end
		end else begin
			wr_en          = done_fire;
			wr_entry.addr  = addr_q;
			wr_entry.stamp = now_q;
			wr_entry.hits  = HITS_W'(1);
			res_idx        = tgt_idx;
		end
	end

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_entry;
		if (rd_en) rd_entry_s1 <= mem[rd_idx_q];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			timeout_q     <= '0;
			limit_q       <= '0;
			entry_vld_q   <= '0;
			rd_idx_q      <= '0;
			rd_en_s1      <= 1'b0;
			hit_found_q   <= 1'b0;
			empty_found_q <= 1'b0;
			old_found_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			rd_en_s1 <= rd_en;

			// configuration writes
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_TIMEOUT: timeout_q <= cfg_wdata[HITS_W-1:0];
					REG_LIMIT:   limit_q   <= cfg_wdata[HITS_W-1:0];
					default:     ;
				endcase
			end

			// read address walk
			if (in_ready) rd_idx_q <= '0;
			else if (rd_en && !scan_last) rd_idx_q <= rd_idx_q + IDX_W'(1);

			// scan flags: first match, first empty, oldest
			if (in_valid && in_ready) begin
				hit_found_q   <= 1'b0;
				empty_found_q <= 1'b0;
				old_found_q   <= 1'b0;
			end else if (rd_en_s1 && !hit_found_q) begin
				if (cur_entry.addr == addr_q) begin
					hit_found_q <= 1'b1;
				end else if (!empty_found_q) begin
					if (cur_entry.addr == '0) empty_found_q <= 1'b1;
					else old_found_q <= 1'b1;
				end
			end

			if (wr_en) entry_vld_q[wr_idx] <= 1'b1;

			if (done_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q  <= cmd;
			addr_q <= station_address;
			now_q  <= now_ms;
		end

		rd_vld_s1 <= entry_vld_q[rd_idx_q];
		rd_idx_s1 <= rd_idx_q;

		if (rd_en_s1 && !hit_found_q) begin
			if (cur_entry.addr == addr_q) begin
				hit_idx_q     <= rd_idx_s1;
				hit_stamp_q   <= cur_entry.stamp;
				hit_hits_q    <= cur_entry.hits;
				hit_elapsed_q <= cur_elapsed;
			end else if (!empty_found_q) begin
				if (cur_entry.addr == '0) begin
					empty_idx_q <= rd_idx_s1;
				end else if (!old_found_q || cur_elapsed > old_elapsed_q) begin
					old_idx_q     <= rd_idx_s1;
					old_elapsed_q <= cur_elapsed;
				end
			end
		end

		if (done_fire) begin
			listed_q  <= res_listed;
			matched_q <= res_matched;
			slot_q    <= SLOT_W'(res_idx);
		end
	end

	assign out_valid  = out_valid_q;
	assign listed     = listed_q;
	assign matched    = matched_q;
	assign slot_index = slot_q;

endmodule

// File: sv/aab_checker.sv
// ----------------------------------------------------------------------------
// aab_checker
// Port-level checks of the blocklist handshakes and result encoding.
// ----------------------------------------------------------------------------
`include "aging_address_blocklist_top_macros.svh"

module aab_checker
	import aab_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              listed,
	input logic              matched,
	input logic [SLOT_W-1:0] slot_index
);

	// a stalled result beat stays
	`AAB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// and keeps its payload
	`AAB_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(listed) && $stable(matched) && $stable(slot_index), "result payload changed while stalled")

	// one item at a time: busy right after an accepted beat
	`AAB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while an item is in flight")

	// listed only for an address present in the table
	`AAB_ASSERT_IMP(a_listed_needs_match, clk, arst_n, out_valid && listed, matched, "listed without a match")

endmodule

bind aging_address_blocklist_top aab_checker u_aab_checker (.*);

// File: verif/aging_address_blocklist_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aging_address_blocklist_top_tb
// Self-checking bench for the station address blocklist. A behavioral copy of
// the table predicts listed/matched/slot for every accepted beat. Directed
// tests cover the empty table, the zero address, timeout and limit edges,
// replacement of the oldest entry, a hit count climbing across its limit and
// output back pressure. Random phases then sweep register settings and
// handshake idling.
// ----------------------------------------------------------------------------
module aging_address_blocklist_top_tb;
	import aab_pkg::*;

	localparam int TBL_N       = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int REPORT_MAX  = 10;

	// index past the two defined registers, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic              listed;
		logic              matched;
		logic [SLOT_W-1:0] slot;
	} verdict_t;

	// DUT connections
	logic                  clk             = 1'b0;
	logic                  arst_n          = 1'b0;
	logic                  cfg_wr_en       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index       = REG_TIMEOUT;
	logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
	logic                  in_valid        = 1'b0;
	logic                  in_ready;
	logic                  cmd             = CMD_ADD;
	logic [ADDR_W-1:0]     station_address = '0;
	logic [STAMP_W-1:0]    now_ms          = '0;
	logic                  out_valid;
	logic                  out_ready       = 1'b0;
	logic                  listed;
	logic                  matched;
	logic [SLOT_W-1:0]     slot_index;

	// shadow of the address table and its registers
	logic [ADDR_W-1:0]     tbl_addr  [TBL_N];
	logic [STAMP_W-1:0]    tbl_stamp [TBL_N];
	logic [HITS_W-1:0]     tbl_hits  [TBL_N];
	logic [CFG_DATA_W-1:0] cfg_timeout = '0;
	logic [CFG_DATA_W-1:0] cfg_limit   = '0;

	verdict_t pending_verdicts [$];

	int fail_count     = 0;
	int results_seen   = 0;
	int listed_seen    = 0;
	int adds_sent      = 0;
	int finds_sent     = 0;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_len       = 0;
	int hold_left      = 0;
	logic hold_go      = 1'b0;
	logic hold_seen    = 1'b0;
	logic [STAMP_W-1:0] now_clock;

	aging_address_blocklist_top #(
		.TABLE_ENTRIES(TBL_N)
	) uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.station_address(station_address),
		.now_ms         (now_ms),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.listed         (listed),
		.matched        (matched),
		.slot_index     (slot_index)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// elapsed ms, modulo 2^32
	function automatic logic [STAMP_W-1:0] age_ms(input logic [STAMP_W-1:0] stamp,
		input logic [STAMP_W-1:0] t);
		return t - stamp;
	endfunction

	// Work out the result of one beat and update the shadow table
	function automatic verdict_t predict_verdict(input logic c, input logic [ADDR_W-1:0] a,
		input logic [STAMP_W-1:0] t);
		int hit_slot;
		int free_slot;
		int stale_slot;
		int target;
		verdict_t v;
		hit_slot   = -1;
		free_slot  = -1;
		stale_slot = -1;
		v          = '0;
		// first match wins; oldest search stops at the first empty slot
		for (int i = 0; i < TBL_N; i++) begin
			if (hit_slot < 0) begin
				if (tbl_addr[i] == a)
					hit_slot = i;
				else if (free_slot < 0) begin
					if (tbl_addr[i] == '0)
						free_slot = i;
					else if (stale_slot < 0 ||
						age_ms(tbl_stamp[i], t) > age_ms(tbl_stamp[stale_slot], t))
						stale_slot = i;
				end
			end
		end
		if (hit_slot >= 0) begin
			v.matched = 1'b1;
			v.slot    = hit_slot[SLOT_W-1:0];
			if (c == CMD_FIND) begin
				if (age_ms(tbl_stamp[hit_slot], t) <= cfg_timeout &&
					tbl_hits[hit_slot] >= cfg_limit)
					v.listed = 1'b1;
			end else if (age_ms(tbl_stamp[hit_slot], t) > cfg_timeout) begin
				// stale entry restarts its count
				tbl_stamp[hit_slot] = t;
				tbl_hits[hit_slot]  = 1;
			end else if (tbl_hits[hit_slot] != HITS_MAX) begin
				tbl_hits[hit_slot] = tbl_hits[hit_slot] + 1'b1;
			end
		end else if (c == CMD_ADD) begin
			target            = (free_slot >= 0) ? free_slot : stale_slot;
			tbl_addr[target]  = a;
			tbl_stamp[target] = t;
			tbl_hits[target]  = 1;
			v.slot            = target[SLOT_W-1:0];
		end
		return v;
	endfunction

	// Offer one beat, hold it until accepted, then log the expected result
	task automatic send_beat(input logic c, input logic [ADDR_W-1:0] a,
		input logic [STAMP_W-1:0] t);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid        = 1'b1;
		cmd             = c;
		station_address = a;
		now_ms          = t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_verdicts.push_back(predict_verdict(c, a, t));
		if (c == CMD_FIND)
			finds_sent++;
		else
			adds_sent++;
	endtask

	// Drop valid and wait for every outstanding result
	task automatic drain_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	// Register write, only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		case (idx)
			REG_TIMEOUT: cfg_timeout = val;
			REG_LIMIT:   cfg_limit   = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Reset registers, empty table and the zero address
	task automatic test_empty_table();
		send_beat(CMD_FIND, '0, 32'd0);
		send_beat(CMD_FIND, 48'h0A1B_2C3D_4E5F, 32'd5);
		send_beat(CMD_ADD, 48'h0A1B_2C3D_4E5F, 32'd5);
		send_beat(CMD_ADD, '0, 32'd7);
		send_beat(CMD_FIND, '0, 32'd7);
		send_beat(CMD_FIND, 48'h0A1B_2C3D_4E5F, 32'd6);
	endtask

	// Elapsed exactly at and just past the timeout, limit edge, time wrap
	task automatic test_timeout_edges();
		drain_results();
		write_reg(REG_TIMEOUT, 16'd100);
		write_reg(REG_LIMIT, 16'd2);
		write_reg(REG_UNUSED, 16'hFFFF);
		send_beat(CMD_ADD, 48'h8000_0000_0001, 32'd1000);
		send_beat(CMD_ADD, 48'h8000_0000_0001, 32'd1100);
		send_beat(CMD_FIND, 48'h8000_0000_0001, 32'd1100);
		send_beat(CMD_FIND, 48'h8000_0000_0001, 32'd1101);
		send_beat(CMD_ADD, 48'h8000_0000_0001, 32'd1201);
		send_beat(CMD_FIND, 48'h8000_0000_0001, 32'd1201);
		send_beat(CMD_ADD, 48'hFFFF_FFFF_FFFE, 32'hFFFF_FFF0);
		send_beat(CMD_ADD, 48'hFFFF_FFFF_FFFE, 32'h0000_0010);
		send_beat(CMD_FIND, 48'hFFFF_FFFF_FFFE, 32'h0000_0010);
	endtask

	// Fill the table, then force replacement with tied stamps
	task automatic test_replacement();
		drain_results();
		write_reg(REG_TIMEOUT, 16'd1000);
		write_reg(REG_LIMIT, 16'd1);
		for (int i = 0; i < 14; i++)
			send_beat(CMD_ADD, {16'hA5A5, 32'(i)}, 32'h0000_2000 + 32'(i / 4));
		send_beat(CMD_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(CMD_FIND, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
	endtask

	// Hold the output off long enough for the input to stall
	task automatic test_backpressure();
		drain_results();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		hold_len = 400;
		hold_go  = ~hold_go;
		for (int i = 0; i < 12; i++)
			send_beat((i % 3 == 2) ? CMD_FIND : CMD_ADD, {16'hA5A5, 32'(i % 5)},
				32'h0000_2100 + 32'(i));
	endtask

	// Climb one count across the limit, asking just below and at it
	task automatic test_hit_limit();
		drain_results();
		write_reg(REG_TIMEOUT, 16'hFFFF);
		write_reg(REG_LIMIT, 16'd20);
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		for (int i = 0; i < 24; i++) begin
			send_beat(CMD_ADD, 48'h5A5A_0000_BEEF, 32'h4000_0000);
			if (i == 18 || i == 19)
				send_beat(CMD_FIND, 48'h5A5A_0000_BEEF, 32'h4000_0000);
		end
	endtask

	// Random beats over a small address pool so entries hit, age and get replaced
	task automatic run_random_phase(input int n_items, input int sidle, input int rstall,
		input logic [CFG_DATA_W-1:0] timeout, input logic [CFG_DATA_W-1:0] limit,
		input int step_max, input int span);
		logic [ADDR_W-1:0] pool [20];
		logic [63:0] r;
		logic [ADDR_W-1:0] a;
		logic c;
		drain_results();
		write_reg(REG_TIMEOUT, timeout);
		write_reg(REG_LIMIT, limit);
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		foreach (pool[i]) begin
			r       = {$urandom, $urandom};
			pool[i] = ($urandom_range(19) == 0) ? '0 : r[ADDR_W-1:0];
		end
		repeat (n_items) begin
			c = ($urandom_range(99) < 35) ? CMD_FIND : CMD_ADD;
			r = {$urandom, $urandom};
			a = ($urandom_range(9) == 0) ? r[ADDR_W-1:0] : pool[$urandom_range(span - 1)];
			// mostly small steps, now and then a jump anywhere
			if ($urandom_range(49) == 0)
				now_clock = $urandom;
			else
				now_clock = now_clock + $urandom_range(step_max);
			send_beat(c, a, now_clock);
		end
	endtask

	// Result side: random stalls plus a counted hold-off
	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result beat with the oldest prediction
	always @(posedge clk) begin : verdict_check
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (listed)
				listed_seen++;
			if (pending_verdicts.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX)
					$display("unexpected result beat: listed=%0b matched=%0b slot=%0d",
						listed, matched, slot_index);
			end else begin
				want = pending_verdicts.pop_front();
				if (listed !== want.listed || matched !== want.matched ||
					slot_index !== want.slot) begin
					fail_count++;
					if (fail_count <= REPORT_MAX)
						$display("result %0d: expected listed=%0b matched=%0b slot=%0d, %s%0b %s%0b %s%0d",
							results_seen, want.listed, want.matched, want.slot,
							"got listed=", listed, "matched=", matched, "slot=", slot_index);
				end
			end
		end
	end

	// Watchdog on cycles without any beat
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no beat for %0d cycles", STALL_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	initial begin
		foreach (tbl_addr[i]) begin
			tbl_addr[i]  = '0;
			tbl_stamp[i] = '0;
			tbl_hits[i]  = '0;
		end
		now_clock = $urandom;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_table();
		test_timeout_edges();
		test_replacement();
		test_backpressure();
		test_hit_limit();
		run_random_phase(200, 0, 0, 16'd40, 16'd3, 3, 8);
		run_random_phase(200, 55, 0, 16'd0, 16'd0, 2, 20);
		run_random_phase(200, 0, 55, 16'hFFFF, 16'd8, 500, 12);
		run_random_phase(200, 14, 14, 16'd300, 16'hFFFF, 20, 20);
		run_random_phase(200, 0, 55, 16'($urandom_range(200)), 16'($urandom_range(5, 1)), 10, 10);
		run_random_phase(150, 14, 14, 16'hFFFF, 16'd0, 1000000, 20);

		drain_results();
		repeat (TBL_N + 8) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			fail_count++;
			$display("%0d results never arrived", pending_verdicts.size());
		end
		$display("Covered %0d add and %0d find beats, %0d results checked, %0d listed.",
			adds_sent, finds_sent, results_seen, listed_seen);
		$display("Registers swept 0..65535, count taken across its limit, idle/stall/hold-off run.");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// File: aging_address_blocklist_top.f
+incdir+sv
sv/aab_pkg.sv
sv/aging_address_blocklist_top.sv
sv/aab_checker.sv
verif/aging_address_blocklist_top_tb.sv
